>>> sv/key_debounce_repeat_longpress_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key debounce unit
// Implication checks in a same-cycle and a next-cycle form.
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_REPEAT_LONGPRESS_UNIT_MACROS_SVH
`define KEY_DEBOUNCE_REPEAT_LONGPRESS_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define KDRL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define KDRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define KDRL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define KDRL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/kdrl_pkg.sv
// ----------------------------------------------------------------------------
// kdrl_pkg
// Shared types, event codes and register indexes of the key debounce unit.
// ----------------------------------------------------------------------------
package kdrl_pkg;

	localparam int unsigned KeyW   = 5;
	localparam int unsigned HoldW  = 16;
	localparam int unsigned CdW    = 8;
	localparam int unsigned EventW = 2;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	localparam logic [EventW-1:0] EV_NONE    = 2'd0;
	localparam logic [EventW-1:0] EV_PRESSED = 2'd1;
	localparam logic [EventW-1:0] EV_LONG    = 2'd2;
	localparam logic [EventW-1:0] EV_REPEAT  = 2'd3;

	localparam logic [CfgIdxW-1:0] REG_DEBOUNCE   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_START_DLY  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_SLOW_INTV  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_SLOW_DUR   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_FAST_INTV  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_LONG_PRESS = 3'd5;

	localparam logic [HoldW-1:0] HOLD_MAX = 16'hFFFF;

	typedef struct packed {
		logic [HoldW-1:0] debounce_ticks;
		logic [CdW-1:0]   repeat_start_delay;
		logic [CdW-1:0]   slow_repeat_interval;
		logic [HoldW-1:0] slow_repeat_duration;
		logic [CdW-1:0]   fast_repeat_interval;
		logic [HoldW-1:0] long_press_ticks;
	} kdrl_cfg_t;

	typedef struct packed {
		logic [KeyW-1:0]  prev_mask;
		logic [HoldW-1:0] hold;
		logic [CdW-1:0]   countdown;
		logic [KeyW-1:0]  code;
	} kdrl_state_t;

	typedef struct packed {
		logic [EventW-1:0] key_event;
		logic [KeyW-1:0]   key_code;
		logic              fired;
	} kdrl_res_t;

endpackage

>>> sv/kdrl_cfg.sv
// ----------------------------------------------------------------------------
// kdrl_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module kdrl_cfg
	import kdrl_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata,
	output kdrl_cfg_t           cfg
);

	kdrl_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks       <= 16'd2;
			cfg_q.repeat_start_delay   <= 8'd15;
			cfg_q.slow_repeat_interval <= 8'd4;
			cfg_q.slow_repeat_duration <= 16'd80;
			cfg_q.fast_repeat_interval <= 8'd2;
			cfg_q.long_press_ticks     <= 16'd40;
		end else if (cfg_we) begin
			// drop bits above each register's width; ignore unknown indexes
			unique case (cfg_index)
				REG_DEBOUNCE:   cfg_q.debounce_ticks       <= cfg_wdata;
				REG_START_DLY:  cfg_q.repeat_start_delay   <= cfg_wdata[CdW-1:0];
				REG_SLOW_INTV:  cfg_q.slow_repeat_interval <= cfg_wdata[CdW-1:0];
				REG_SLOW_DUR:   cfg_q.slow_repeat_duration <= cfg_wdata;
				REG_FAST_INTV:  cfg_q.fast_repeat_interval <= cfg_wdata[CdW-1:0];
				REG_LONG_PRESS: cfg_q.long_press_ticks     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/kdrl_tick.sv
// ----------------------------------------------------------------------------
// kdrl_tick
// Next-state and event logic for one scan tick.
// ----------------------------------------------------------------------------
module kdrl_tick
	import kdrl_pkg::*;
(
	input  logic [KeyW-1:0] pin_levels,
	input  kdrl_state_t     cur,
	input  kdrl_cfg_t       cfg,
	output kdrl_state_t     nxt,
	output kdrl_res_t       res
);

	logic [KeyW-1:0]  mask;
	logic [HoldW-1:0] hold_inc;
	logic [CdW-1:0]   cd_dec;

	assign mask     = ~pin_levels;
	assign hold_inc = (cur.hold == HOLD_MAX) ? cur.hold : cur.hold + 16'd1;
	assign cd_dec   = cur.countdown - 8'd1;

	always_comb begin
		nxt           = cur;
		res.key_event = EV_NONE;
		res.fired     = 1'b0;
		if (mask != cur.prev_mask) begin
			// new mask: restart the hold and clear the code, hold the countdown as it is
			nxt.prev_mask = mask;
			nxt.hold      = '0;
			nxt.code      = '0;
		end else begin
			nxt.hold = hold_inc;
			priority if (hold_inc == cfg.debounce_ticks) begin
				res.key_event = EV_PRESSED;
				res.fired     = 1'b1;
				nxt.code      = mask;
				nxt.countdown = cfg.repeat_start_delay;
			end else if (hold_inc == cfg.long_press_ticks) begin
				res.key_event = EV_LONG;
				res.fired     = 1'b1;
				nxt.code      = mask;
			end else if (cur.countdown != '0) begin
				nxt.countdown = cd_dec;
				if (cd_dec == '0) begin
					res.key_event = EV_REPEAT;
					res.fired     = 1'b1;
					nxt.code      = mask;
					nxt.countdown = (hold_inc < cfg.slow_repeat_duration)
						? cfg.slow_repeat_interval : cfg.fast_repeat_interval;
				end
			end else begin
				res.key_event = EV_NONE;
			end
		end
		res.key_code = nxt.code;
	end

endmodule

>>> sv/key_debounce_repeat_longpress_unit.sv
// ----------------------------------------------------------------------------
// key_debounce_repeat_longpress_unit
// Keypad debounce with press, long-press and auto-repeat events.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | sink      | in_valid / in_stall  | pin_levels
//  out     | source    | out_valid / out_stall| key_event, key_code, event_fired
//  cfg     | sink      | cfg_we               | cfg_index, cfg_wdata
//
//  One scan tick per clock while the output is not stalled: a tick transfers
//  into the input stage (_s1), is evaluated against the hold state and loads
//  the result register, from which its result can transfer.
//  A stalled result holds the result register; the input stage still takes
//  one more tick, and in_stall rises only when both stages are full.
//  Reset clears valids and hold state and loads the register defaults.
//
`include "key_debounce_repeat_longpress_unit_macros.svh"

module key_debounce_repeat_longpress_unit
	import kdrl_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// scan tick input
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [KeyW-1:0]     pin_levels,
	// event output
	output logic                out_valid,
	input  logic                out_stall,
	output logic [EventW-1:0]   key_event,
	output logic [KeyW-1:0]     key_code,
	output logic                event_fired,
	// configuration writes
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata
);

	kdrl_cfg_t   cfg;
	kdrl_state_t state_q;
	kdrl_state_t state_nxt;
	kdrl_res_t   res;

	logic            valid_s1;
	logic [KeyW-1:0] pin_s1;
	logic            out_valid_q;
	kdrl_res_t       res_q;

	logic advance;
	logic in_xfer;

	logic fired_agrees;
	logic mask_change_s1;
	logic hold_cleared;

	// result register free, or its content leaves this cycle
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	kdrl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	kdrl_tick u_tick (
		.pin_levels (pin_s1),
		.cur        (state_q),
		.cfg        (cfg),
		.nxt        (state_nxt),
		.res        (res)
	);

	// input stage: refill whenever the held tick moves on or the stage is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pin_s1 <= pin_levels;
		end
	end

	// hold state: commit the tick as it enters the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign key_event   = res_q.key_event;
	assign key_code    = res_q.key_code;
	assign event_fired = res_q.fired;

	assign fired_agrees   = event_fired == (key_event != EV_NONE);
	assign mask_change_s1 = valid_s1 && advance && ((~pin_s1) != state_q.prev_mask);
	assign hold_cleared   = state_q.hold == '0 && key_event == EV_NONE && key_code == '0;

	// the fired flag and the event code must agree
	`KDRL_ASSERT_NOW(a_fired_matches_event, clk, arst_n, out_valid_q, fired_agrees)
	// input stalls only with a tick waiting in the input stage
	`KDRL_ASSERT_NOW(a_stall_needs_s1, clk, arst_n, in_stall, valid_s1 && out_valid_q)
	// a changed mask restarts the hold and reports no event with code 0
	`KDRL_ASSERT_NEXT(a_mask_change, clk, arst_n, mask_change_s1, hold_cleared)

endmodule
